@@ rtl/mcpg_pkg.sv @@
`default_nettype none

package mcpg_pkg;

  localparam int COORD_W  = 14;
  localparam int CENTER_W = 12;
  localparam int RADIN_W  = 11;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 8'd1;

  localparam logic [CENTER_W-1:0] CENTER_X_RESET = 12'd320;
  localparam logic [CENTER_W-1:0] CENTER_Y_RESET = 12'd240;

  localparam logic MODE_START   = 1'b0;
  localparam logic MODE_ADVANCE = 1'b1;

  localparam logic [2:0] POINT_LAST = 3'd7;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t off_x;
    coord_t off_y;
    logic   has_point;
    logic   done;
  } step_t;

endpackage

`default_nettype wire

@@ rtl/mcpg_if.sv @@
`default_nettype none

interface mcpg_in_if;
  import mcpg_pkg::*;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [RADIN_W-1:0] radius;
  modport source (output valid, mode, radius, input ready);
  modport sink (input valid, mode, radius, output ready);
endinterface

interface mcpg_out_if;
  import mcpg_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic                      point_valid;
  logic                      last_of_step;
  logic                      circle_done;
  modport source (output valid, point_x, point_y, point_valid, last_of_step, circle_done,
                  input ready);
  modport sink (input valid, point_x, point_y, point_valid, last_of_step, circle_done,
                output ready);
endinterface

interface mcpg_cfg_if;
  import mcpg_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CENTER_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/mcpg_front.sv @@
`default_nettype none

module mcpg_front #(
  parameter int RADIUS_BITS = 11
) (
  input  wire logic           clk,
  input  wire logic           rst,
  mcpg_in_if.sink             item,
  input  wire logic           full,
  output logic                push,
  output mcpg_pkg::step_t     push_step
);
  import mcpg_pkg::*;

  localparam int DW = RADIUS_BITS + 3;

  logic [RADIUS_BITS-1:0] offset_x, offset_x_next;
  logic [RADIUS_BITS-1:0] offset_y, offset_y_next;
  logic [DW-1:0]          decision, decision_next;
  logic                   finished, finished_next;

  logic [RADIUS_BITS-1:0] r;
  logic [RADIUS_BITS-1:0] x_inc;
  logic [RADIUS_BITS-1:0] y_dec;
  logic [DW-1:0]          x_ext;
  logic [DW-1:0]          diff;
  logic                   noop;

  assign item.ready = !full;
  assign push       = item.valid && item.ready;

  assign r     = RADIUS_BITS'(item.radius);
  assign x_inc = offset_x + 1'b1;
  assign y_dec = offset_y - 1'b1;
  assign x_ext = {3'b000, x_inc};
  assign diff  = x_ext - {3'b000, y_dec};
  assign noop  = (item.mode == MODE_ADVANCE) && finished;

  always_comb begin
    offset_x_next = offset_x;
    offset_y_next = offset_y;
    decision_next = decision;
    finished_next = finished;
    if (item.mode == MODE_START) begin
      offset_x_next = '0;
      offset_y_next = r;
      decision_next = DW'(1) - {3'b000, r};
      finished_next = (r == '0);
    end else if (!finished) begin
      offset_x_next = x_inc;
      if (decision[DW-1]) begin
        decision_next = decision + {x_ext[DW-2:0], 1'b0} + DW'(1);
      end else begin
        offset_y_next = y_dec;
        decision_next = decision + {diff[DW-2:0], 1'b0} + DW'(1);
      end
      finished_next = !(offset_x_next < offset_y_next);
    end
  end

  always_comb begin
    push_step.off_x     = noop ? '0 : COORD_W'(offset_x_next);
    push_step.off_y     = noop ? '0 : COORD_W'(offset_y_next);
    push_step.has_point = !noop;
    push_step.done      = finished_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x <= '0;
      offset_y <= '0;
      decision <= '0;
      finished <= 1'b1;
    end else if (push) begin
      offset_x <= offset_x_next;
      offset_y <= offset_y_next;
      decision <= decision_next;
      finished <= finished_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/mcpg_queue.sv @@
`default_nettype none

module mcpg_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire mcpg_pkg::step_t  wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic                  rd_valid,
  output mcpg_pkg::step_t       rd_data
);
  import mcpg_pkg::*;

  step_t       slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full     = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= !wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(wr_en) - 2'(rd_en);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !wr_en)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) rd_en |-> rd_valid)
    else $error("queue read while empty");

endmodule

`default_nettype wire

@@ rtl/mcpg_back.sv @@
`default_nettype none

module mcpg_back (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           head_valid,
  input  wire mcpg_pkg::step_t                head,
  output logic                                pop,
  input  wire logic [mcpg_pkg::CENTER_W-1:0]  center_x,
  input  wire logic [mcpg_pkg::CENTER_W-1:0]  center_y,
  mcpg_out_if.source                          result
);
  import mcpg_pkg::*;

  logic [2:0] k;
  logic       out_valid;
  logic       emit;
  logic       last;
  logic       swap;
  logic       neg_x;
  logic       neg_y;
  coord_t     ox;
  coord_t     oy;
  coord_t     cx;
  coord_t     cy;
  coord_t     px;
  coord_t     py;

  assign emit = head_valid && (!out_valid || result.ready);
  assign last = !head.has_point || (k == POINT_LAST);
  assign pop  = emit && last;

  always_comb begin
    swap  = 1'b0;
    neg_y = 1'b0;
    unique case (k) inside
      3'd2, 3'd7:       swap = 1'b1;
      3'd3, 3'd5: begin
        swap  = 1'b1;
        neg_y = 1'b1;
      end
      3'd1, 3'd4:       neg_y = 1'b1;
      default:          swap = 1'b0;
    endcase
  end

  assign neg_x = k[2];
  assign ox    = swap ? head.off_y : head.off_x;
  assign oy    = swap ? head.off_x : head.off_y;
  assign cx    = COORD_W'(center_x);
  assign cy    = COORD_W'(center_y);
  assign px    = neg_x ? cx - ox : cx + ox;
  assign py    = neg_y ? cy - oy : cy + oy;

  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        k         <= last ? 3'd0 : k + 3'd1;
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.point_x      <= head.has_point ? px : '0;
      result.point_y      <= head.has_point ? py : '0;
      result.point_valid  <= head.has_point;
      result.last_of_step <= last;
      result.circle_done  <= last && head.done;
    end
  end

  assign result.valid = out_valid;

  a_mid_step_head: assert property (@(posedge clk) disable iff (rst)
      (k != 3'd0) |-> head_valid && head.has_point)
    else $error("step counter running without a point step at the head");

  a_nopoint_marks: assert property (@(posedge clk) disable iff (rst)
      out_valid && !result.point_valid |-> result.last_of_step && result.circle_done)
    else $error("no-point word without last and done marks");

  a_done_on_last: assert property (@(posedge clk) disable iff (rst)
      out_valid && result.circle_done |-> result.last_of_step)
    else $error("done mark off the last word of a step");

endmodule

`default_nettype wire

@@ rtl/midpoint_circle_point_generator_unit.sv @@
// Each accepted input word is written into the step queue, and its points are registered from the
//   queue head into the output register of the point emitter.
// Each step item gives eight points, one per cycle on the result port while result.ready allows;
//   an advance after completion gives one no-point word.
// A two-entry step queue sits between the stepping front and the point emitter.
// Reset (rst, synchronous): center 320/240, no circle active, queue and output empty.
`default_nettype none

module midpoint_circle_point_generator_unit #(
  parameter int RADIUS_BITS = 11
) (
  input  wire logic    clk,
  input  wire logic    rst,
  mcpg_in_if.sink      item,
  mcpg_cfg_if.sink     cfg,
  mcpg_out_if.source   result
);
  import mcpg_pkg::*;

  logic [CENTER_W-1:0] center_x;
  logic [CENTER_W-1:0] center_y;
  logic                push;
  step_t               push_step;
  logic                full;
  logic                pop;
  logic                head_valid;
  step_t               head;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= CENTER_X_RESET;
      center_y <= CENTER_Y_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == REG_CENTER_X) begin
        center_x <= cfg.data;
      end else if (cfg.index == REG_CENTER_Y) begin
        center_y <= cfg.data;
      end
    end
  end

  mcpg_front #(
    .RADIUS_BITS (RADIUS_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .full      (full),
    .push      (push),
    .push_step (push_step)
  );

  mcpg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (push),
    .wr_data  (push_step),
    .full     (full),
    .rd_en    (pop),
    .rd_valid (head_valid),
    .rd_data  (head)
  );

  mcpg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .center_x   (center_x),
    .center_y   (center_y),
    .result     (result)
  );

endmodule

`default_nettype wire

@@ dv/midpoint_circle_point_generator_unit_tb.sv @@
`timescale 1ns / 1ps

module midpoint_circle_point_generator_unit_tb;
  import mcpg_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 10;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_WORDS  = 105;
  localparam int STALL_LIMIT   = 4000;
  localparam int SMALL_RADIUS  = 16;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   has_point;
    logic   last;
    logic   done;
  } pixel_t;

  typedef enum logic [1:0] {
    DRAIN_FULL,
    DRAIN_MOSTLY,
    DRAIN_RARELY,
    DRAIN_EVERY_THIRD
  } drain_style_t;

  logic clk = 1'b0;
  logic rst;

  mcpg_in_if  item_if ();
  mcpg_cfg_if cfg_if ();
  mcpg_out_if point_if ();

  midpoint_circle_point_generator_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .cfg    (cfg_if),
    .result (point_if)
  );

  always #HALF_PERIOD clk = ~clk;

  logic [CENTER_W-1:0] center_x;
  logic [CENTER_W-1:0] center_y;
  logic [RADIN_W-1:0]  arc_x;
  logic [RADIN_W-1:0]  arc_y;
  int                  arc_err;
  logic                circle_over;

  pixel_t pending_points [$];
  pixel_t want;

  int mismatches;
  int words_sent;
  int burst_left;
  int starts_sent;
  int steps_sent;
  int idle_advances;
  int circles_closed;
  int reg_writes;
  int points_checked;
  int stall_cycles;

  drain_style_t drain_style;
  int           drain_left;

  function automatic logic [CENTER_W-1:0] pick_coord();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return CENTER_W'($urandom);
    endcase
  endfunction

  function automatic void emit_octants();
    int     xo;
    int     yo;
    int     cxi;
    int     cyi;
    int     px [8];
    int     py [8];
    pixel_t p;
    xo  = int'(arc_x);
    yo  = int'(arc_y);
    cxi = int'(center_x);
    cyi = int'(center_y);
    px[0] = cxi + xo; py[0] = cyi + yo;
    px[1] = cxi + xo; py[1] = cyi - yo;
    px[2] = cxi + yo; py[2] = cyi + xo;
    px[3] = cxi + yo; py[3] = cyi - xo;
    px[4] = cxi - xo; py[4] = cyi - yo;
    px[5] = cxi - yo; py[5] = cyi - xo;
    px[6] = cxi - xo; py[6] = cyi + yo;
    px[7] = cxi - yo; py[7] = cyi + xo;
    for (int k = 0; k < 8; k++) begin
      p.x         = coord_t'(px[k]);
      p.y         = coord_t'(py[k]);
      p.has_point = 1'b1;
      p.last      = (k == POINT_LAST);
      p.done      = (k == POINT_LAST) && circle_over;
      pending_points.push_back(p);
    end
    if (circle_over) circles_closed++;
  endfunction

  function automatic void rasterize_item(input logic mode, input logic [RADIN_W-1:0] radius);
    pixel_t p;
    if (mode == MODE_START) begin
      arc_x       = '0;
      arc_y       = radius;
      arc_err     = 1 - int'(radius);
      circle_over = !(arc_x < arc_y);
      starts_sent++;
      emit_octants();
    end else if (circle_over) begin
      p.x         = '0;
      p.y         = '0;
      p.has_point = 1'b0;
      p.last      = 1'b1;
      p.done      = 1'b1;
      pending_points.push_back(p);
      idle_advances++;
    end else begin
      arc_x = arc_x + 1'b1;
      if (arc_err < 0) begin
        arc_err = arc_err + 2 * int'(arc_x) + 1;
      end else begin
        arc_y   = arc_y - 1'b1;
        arc_err = arc_err + 2 * (int'(arc_x) - int'(arc_y)) + 1;
      end
      circle_over = !(arc_x < arc_y);
      steps_sent++;
      emit_octants();
    end
  endfunction

  function automatic void compare_field(input string name, input int expd, input int got);
    if (expd != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, expd, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && point_if.valid && point_if.ready) begin
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected point word, expected none actual x=%0d y=%0d valid=%0b",
                 $time, point_if.point_x, point_if.point_y, point_if.point_valid);
        mismatches++;
      end else begin
        want = pending_points.pop_front();
        compare_field("point_x", int'($signed(want.x)), int'(point_if.point_x));
        compare_field("point_y", int'($signed(want.y)), int'(point_if.point_y));
        compare_field("point_valid", int'(want.has_point), int'(point_if.point_valid));
        compare_field("last_of_step", int'(want.last), int'(point_if.last_of_step));
        compare_field("circle_done", int'(want.done), int'(point_if.circle_done));
      end
      points_checked++;
    end
  end

  initial begin
    point_if.ready <= 1'b0;
    drain_left = 0;
    forever begin
      @(posedge clk);
      if (drain_left == 0) begin
        drain_style = drain_style_t'($urandom_range(0, 3));
        drain_left  = $urandom_range(8, 80);
      end
      drain_left--;
      case (drain_style)
        DRAIN_FULL:   point_if.ready <= 1'b1;
        DRAIN_MOSTLY: point_if.ready <= ($urandom_range(0, 3) != 0);
        DRAIN_RARELY: point_if.ready <= ($urandom_range(0, 3) == 0);
        default:      point_if.ready <= (drain_left % 3 != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (item_if.valid && item_if.ready) || (cfg_if.valid && cfg_if.ready)
        || (point_if.valid && point_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d points outstanding",
               $time, STALL_LIMIT, pending_points.size());
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_word(input logic mode, input logic [RADIN_W-1:0] radius);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        item_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_if.valid  <= 1'b1;
    item_if.mode   <= mode;
    item_if.radius <= radius;
    do @(posedge clk); while (!item_if.ready);
    rasterize_item(mode, radius);
    words_sent++;
  endtask

  // hold the item port until every point has drained
  task automatic settle_block();
    item_if.valid <= 1'b0;
    do @(posedge clk); while (pending_points.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CENTER_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    if (index == REG_CENTER_X) center_x = value;
    else if (index == REG_CENTER_Y) center_y = value;
    reg_writes++;
  endtask

  task automatic move_center(input logic [CENTER_W-1:0] cx, input logic [CENTER_W-1:0] cy,
                             input bit stray);
    settle_block();
    write_reg(REG_CENTER_X, cx);
    if (stray) begin
      write_reg(CFG_IDX_W'($urandom_range(int'(REG_CENTER_Y) + 1, (1 << CFG_IDX_W) - 1)),
                CENTER_W'($urandom));
    end
    write_reg(REG_CENTER_Y, cy);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic trace_circle(input logic [RADIN_W-1:0] radius, input int extra);
    send_word(MODE_START, radius);
    while (!circle_over) send_word(MODE_ADVANCE, RADIN_W'($urandom));
    repeat (extra) send_word(MODE_ADVANCE, RADIN_W'($urandom));
  endtask

  task automatic test_after_reset();
    send_word(MODE_ADVANCE, '1);
    trace_circle(RADIN_W'(3), 1);
  endtask

  task automatic test_zero_radius();
    trace_circle('0, 1);
  endtask

  task automatic test_center_corners();
    move_center('0, '0, 1'b1);
    send_word(MODE_START, '1);
    repeat (3) send_word(MODE_ADVANCE, '0);
    trace_circle(RADIN_W'(1), 0);
    move_center('1, '1, 1'b0);
    send_word(MODE_START, '1);
    repeat (2) send_word(MODE_ADVANCE, '1);
  endtask

  task automatic test_center_moved_mid_circle();
    send_word(MODE_START, RADIN_W'(6));
    repeat (2) send_word(MODE_ADVANCE, RADIN_W'($urandom));
    move_center(pick_coord(), pick_coord(), 1'b1);
    while (!circle_over) send_word(MODE_ADVANCE, RADIN_W'($urandom));
  endtask

  task automatic test_random_traffic();
    int target;
    target = words_sent + RANDOM_WORDS;
    while (words_sent < target) begin
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 3) == 0) begin
          move_center(pick_coord(), pick_coord(), 1'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 4) == 0) begin
          send_word(MODE_START, RADIN_W'($urandom));
          repeat ($urandom_range(0, 6)) send_word(MODE_ADVANCE, RADIN_W'($urandom));
        end else begin
          trace_circle(RADIN_W'($urandom_range(0, SMALL_RADIUS)), $urandom_range(0, 2));
        end
      end else begin
        repeat ($urandom_range(1, 4)) send_word(1'($urandom_range(0, 1)), RADIN_W'($urandom));
      end
    end
  endtask

  initial begin
    rst            <= 1'b1;
    item_if.valid  <= 1'b0;
    item_if.mode   <= MODE_START;
    item_if.radius <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.index   <= REG_CENTER_X;
    cfg_if.data    <= '0;
    center_x       = CENTER_X_RESET;
    center_y       = CENTER_Y_RESET;
    arc_x          = '0;
    arc_y          = '0;
    arc_err        = 0;
    circle_over    = 1'b1;
    mismatches     = 0;
    words_sent     = 0;
    burst_left     = 0;
    starts_sent    = 0;
    steps_sent     = 0;
    idle_advances  = 0;
    circles_closed = 0;
    reg_writes     = 0;
    points_checked = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_after_reset();
    test_zero_radius();
    test_center_corners();
    test_center_moved_mid_circle();
    test_random_traffic();
    settle_block();

    $display("ran %0d item words: %0d starts, %0d steps, %0d advances past the end",
             words_sent, starts_sent, steps_sent, idle_advances);
    $display("%0d circles completed, %0d register writes, %0d point words checked",
             circles_closed, reg_writes, points_checked);
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
